[hdl/lpr_pkg.sv]
package lpr_pkg;

    // fixed widths of the result fields and the capacity register
    localparam int CFG_W   = 5;
    localparam int EV_W    = 16;
    localparam int FAULT_W = 32;
    localparam int OCC_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // link handed from one recency cell to the next
    typedef struct packed {
        logic valid;  // neighbor holds a live page
        logic found;  // request matched at this position or a more recent one
    } t_link;

endpackage

[hdl/lpr_cell.sv]
module lpr_cell import lpr_pkg::*; #(
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  logic                 i_in_cap,
    input  logic [PAGE_BITS-1:0] i_req_page,
    input  logic [PAGE_BITS-1:0] i_prev_page,
    input  t_link                i_prev,
    output logic [PAGE_BITS-1:0] o_page,
    output t_link                o_link
);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic                 eff_valid;
    logic                 match;
    logic                 shift;

    // entries at or beyond the capacity drop out silently
    assign eff_valid = r_valid & i_in_cap;
    assign match     = eff_valid && (r_page == i_req_page);
    assign shift     = ~i_prev.found;

    assign o_page       = r_page;
    assign o_link.valid = eff_valid;
    assign o_link.found = i_prev.found | match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_update) begin
            if (shift) begin
                r_valid <= i_prev.valid & i_in_cap;
            end else begin
                r_valid <= eff_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update && shift) begin
            r_page <= i_prev_page;
        end
    end

endmodule

[hdl/lru_page_replacement_core.sv]
// lru page replacement, fully associative recency stack
// a request is captured into r_page, then one compare-and-shift pass through
//   the recency cell row writes the result register; one request at a time,
//   and a stalled full result register holds the pass and new requests back
// reset: synchronous active-low i_rst_n empties the stack, clears the fault
//   count and sets the capacity to 16; no clearing pass is needed
module lru_page_replacement_core import lpr_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int PAGE_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // capacity register
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // request side
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PAGE_BITS-1:0] i_page,
    // result side
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic                 o_evicted_valid,
    output logic [EV_W-1:0]      o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_count,
    output logic [OCC_W-1:0]     o_occupancy
);

    // count width holds 0..MAX_ENTRIES
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int EXT_W = (PAGE_BITS > EV_W) ? PAGE_BITS : EV_W;
    localparam int OEX_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    // control and bookkeeping
    logic [CFG_W-1:0]     r_cap;
    logic                 r_busy;
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_occ;
    logic [FAULT_W-1:0]   r_faults;

    // result register
    logic                 r_out_valid;
    logic                 r_hit;
    logic                 r_ev_valid;
    logic [EV_W-1:0]      r_ev_page;
    logic [FAULT_W-1:0]   r_fault_out;
    logic [OCC_W-1:0]     r_occ_out;

    logic                 accept;
    logic                 update;
    logic [CMP_W-1:0]     cap_ext;
    logic [CNT_W-1:0]     cap_eff;
    logic [CNT_W-1:0]     occ_eff;
    logic                 full;
    logic                 hit;
    logic                 evict;
    logic [PAGE_BITS-1:0] ev_page;
    logic [EXT_W-1:0]     ev_ext;
    logic [CNT_W-1:0]     n_occ;
    logic [OEX_W-1:0]     occ_ext;
    logic [FAULT_W-1:0]   n_faults;

    // the row of cells: index 0 is the request, index i+1 is cell i
    t_link                chain_link [0:MAX_ENTRIES];
    logic [PAGE_BITS-1:0] chain_page [0:MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] in_cap;

    // one request in flight; the result register lets the next one in
    // while a finished result waits
    assign o_in_stall = r_busy;
    assign accept     = i_in_valid & ~r_busy;
    assign update     = r_busy & (~r_out_valid | ~i_out_stall);

    // capacity in effect: zero acts as one, clipped to the built depth
    assign cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            cap_eff = cap_ext[CNT_W-1:0];
        end
    end

    // live entries stay contiguous from the most recent one, so the
    // occupancy is a count trimmed to the capacity
    assign occ_eff = (r_occ > cap_eff) ? cap_eff : r_occ;
    assign full    = (occ_eff == cap_eff);

    assign chain_link[0] = '{valid: 1'b1, found: 1'b0};
    assign chain_page[0] = r_page;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            assign in_cap[gi] = (CNT_W'(gi) < cap_eff);

            lpr_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_update    (update),
                .i_in_cap    (in_cap[gi]),
                .i_req_page  (r_page),
                .i_prev_page (chain_page[gi]),
                .i_prev      (chain_link[gi]),
                .o_page      (chain_page[gi+1]),
                .o_link      (chain_link[gi+1])
            );
        end
    endgenerate

    // a match anywhere in the row ripples out of the last cell
    assign hit   = chain_link[MAX_ENTRIES].found;
    assign evict = ~hit & full;

    // least recently used page sits in the last cell inside the capacity
    assign ev_page = evict ? chain_page[cap_eff] : '0;
    assign ev_ext  = EXT_W'(ev_page);

    always_comb begin
        if (hit) begin
            n_occ = occ_eff;
        end else if (full) begin
            n_occ = cap_eff;
        end else begin
            n_occ = occ_eff + CNT_W'(1);
        end
    end
    assign occ_ext = OEX_W'(n_occ);

    // saturating fault counter
    assign n_faults = (!hit && (r_faults != '1)) ? r_faults + FAULT_W'(1) : r_faults;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_busy      <= 1'b0;
            r_occ       <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (update) begin
                r_busy <= 1'b0;
            end
            if (update) begin
                r_occ       <= n_occ;
                r_faults    <= n_faults;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page;
        end
        if (update) begin
            r_hit       <= hit;
            r_ev_valid  <= evict;
            r_ev_page   <= ev_ext[EV_W-1:0];
            r_fault_out <= n_faults;
            r_occ_out   <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_fault_out;
    assign o_occupancy     = r_occ_out;

endmodule

[hdl/lpr_checker.sv]
module lpr_checker import lpr_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 i_in_valid,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_hit,
    input logic                 o_evicted_valid,
    input logic [EV_W-1:0]      o_evicted_page,
    input logic [FAULT_W-1:0]   o_fault_count,
    input logic [OCC_W-1:0]     o_occupancy
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit)
            && $stable(o_evicted_page) && $stable(o_fault_count)
            && $stable(o_occupancy))
        else $error("stalled result changed");

    // only one request in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // no eviction means a zero evicted page
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_page == '0)
        else $error("evicted page not zero without eviction");

    // every result leaves at least one resident page
    a_occ_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occupancy != '0)
        else $error("empty stack after a request");

endmodule

bind lru_page_replacement_core lpr_checker u_lpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .i_in_valid      (i_in_valid),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page),
    .o_fault_count   (o_fault_count),
    .o_occupancy     (o_occupancy)
);

[sim/tb_lru_page_replacement_core.sv]
`timescale 1ns / 1ps

module tb_lru_page_replacement_core;
    import lpr_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int PAGE_W      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_REQS  = 175;
    localparam int POOL_MAX    = 40;

    // one expected lookup outcome, in result field order
    typedef struct packed {
        logic               hit;
        logic               ev_valid;
        logic [EV_W-1:0]    ev_page;
        logic [FAULT_W-1:0] faults;
        logic [OCC_W-1:0]   occ;
    } t_outcome;

    // tracks the recency stack and queues the outcome of every accepted request
    class lru_stack_tracker;
        logic [PAGE_W-1:0]  stack_page [ENTRIES];
        bit                 stack_valid [ENTRIES];
        logic [FAULT_W-1:0] fault_total;
        logic [CFG_W-1:0]   capacity;
        t_outcome           outcome_q [$];
        int unsigned        failures;

        function new();
            foreach (stack_page[i]) begin
                stack_page[i]  = '0;
                stack_valid[i] = 1'b0;
            end
            fault_total = '0;
            capacity    = CAP_RESET;
            failures    = 0;
        endfunction

        function void note_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_reference(logic [PAGE_W-1:0] pg);
            int       eff;
            int       occ;
            int       pos;
            bit       found;
            t_outcome o;
            eff   = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
            occ   = 0;
            pos   = 0;
            found = 1'b0;
            o     = '0;
            // entries beyond the capacity in effect go away without an eviction
            for (int i = eff; i < ENTRIES; i++) begin
                stack_valid[i] = 1'b0;
                stack_page[i]  = '0;
            end
            while (occ < eff && stack_valid[occ])
                occ++;
            for (int i = occ; i < eff; i++) begin
                stack_valid[i] = 1'b0;
                stack_page[i]  = '0;
            end
            for (int i = 0; i < occ; i++) begin
                if (!found && stack_page[i] == pg) begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (found) begin
                for (int i = pos; i > 0; i--)
                    stack_page[i] = stack_page[i-1];
                stack_page[0] = pg;
                o.hit = 1'b1;
            end else begin
                if (occ == eff) begin
                    o.ev_valid = 1'b1;
                    o.ev_page  = stack_page[eff-1];
                    stack_valid[eff-1] = 1'b0;
                    stack_page[eff-1]  = '0;
                    occ = eff - 1;
                end
                for (int i = occ; i > 0; i--)
                    stack_page[i] = stack_page[i-1];
                stack_page[0]    = pg;
                stack_valid[occ] = 1'b1;
                occ++;
                if (fault_total != '1)
                    fault_total++;
            end
            o.faults = fault_total;
            o.occ    = occ[OCC_W-1:0];
            outcome_q = {outcome_q, o};
        endfunction

        function void check_outcome(logic hit, logic ev_valid, logic [EV_W-1:0] ev_page,
                                    logic [FAULT_W-1:0] faults, logic [OCC_W-1:0] occ);
            t_outcome e;
            if (outcome_q.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            e = outcome_q.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, actual %0d", e.hit, hit);
                failures++;
            end
            if (ev_valid !== e.ev_valid) begin
                $error("evicted_valid: expected %0d, actual %0d", e.ev_valid, ev_valid);
                failures++;
            end
            if (ev_page !== e.ev_page) begin
                $error("evicted_page: expected %h, actual %h", e.ev_page, ev_page);
                failures++;
            end
            if (faults !== e.faults) begin
                $error("fault_count: expected %0d, actual %0d", e.faults, faults);
                failures++;
            end
            if (occ !== e.occ) begin
                $error("occupancy: expected %0d, actual %0d", e.occ, occ);
                failures++;
            end
        endfunction
    endclass

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // capacity register port
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // request side
    logic              in_valid = 1'b0;
    logic [PAGE_W-1:0] in_page  = '0;
    logic              o_in_stall;

    // result side
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic               o_hit;
    logic               o_evicted_valid;
    logic [EV_W-1:0]    o_evicted_page;
    logic [FAULT_W-1:0] o_fault_count;
    logic [OCC_W-1:0]   o_occupancy;

    // idling controls shared between the stimulus and the result process
    bit send_idle    = 1'b1;
    bit recv_idle    = 1'b1;
    bit hold_request = 1'b0;

    int unsigned cycle_count = 0;

    lru_stack_tracker tracker = new();

    lru_page_replacement_core #(
        .MAX_ENTRIES (ENTRIES),
        .PAGE_BITS   (PAGE_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_page          (in_page),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count),
        .o_occupancy     (o_occupancy)
    );

    // 4 ns period
    always #2 i_clk = ~i_clk;

    // watchdog, sized far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // wait time before the next request, zero when the sender runs flat out
    function automatic int draw_gap();
        return send_idle ? int'($urandom_range(0, 14)) : 0;
    endfunction

    // offer one request after a gap and hold it until the block takes it
    task automatic send_page(input logic [PAGE_W-1:0] pg, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_page  <= pg;
        do
            @(posedge i_clk);
        while (o_in_stall);
        tracker.note_reference(pg);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        // then idle before the next phase
        repeat (4) @(negedge i_clk);
    endtask

    // capacity write, only issued while the block is idle
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        tracker.note_capacity(value);
    endtask

    // result side: random stall per result, one long hold-off on demand
    initial begin
        int hold_len;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long back-pressure so the block fills and stalls requests
                hold_request = 1'b0;
                hold_len     = HOLD_CYCLES;
            end else begin
                hold_len = recv_idle ? int'($urandom_range(0, 14)) : 0;
            end
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge i_clk);
            while (!o_out_valid);
            tracker.check_outcome(o_hit, o_evicted_valid, o_evicted_page,
                                  o_fault_count, o_occupancy);
        end
    end

    // stimulus
    initial begin
        logic [PAGE_W-1:0] fill_pages [19] = '{
            16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF,
            16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0007,
            16'h0008, 16'h0009, 16'h000A, 16'h1234, 16'h1234
        };
        logic [PAGE_W-1:0] pool [POOL_MAX];
        logic [PAGE_W-1:0] pg;
        logic [CFG_W-1:0]  cap;
        int                pool_n;

        // synchronous reset held, then released on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacity: hit on the lru entry early on, fill all 16 frames with
        // extreme page numbers, then evict the lru entry and hit on the mru entry
        foreach (fill_pages[i])
            send_page(fill_pages[i], draw_gap());
        drain();

        // capacity lowered below occupancy: extra entries are dropped silently
        write_capacity(5'd3);
        send_page(16'hAAAA, draw_gap());
        send_page(16'h000A, draw_gap());
        drain();

        // capacity zero behaves as a single frame
        write_capacity(5'd0);
        send_page(16'h0F0F, draw_gap());
        send_page(16'h0F0F, draw_gap());
        send_page(16'hF0F0, draw_gap());
        drain();

        // random phases: pages mostly from a small pool so hits and evictions mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cap = 5'd31;   // above the entry count, acts as 16
                1:       cap = 5'd17;
                2:       cap = 5'd1;
                3:       cap = 5'd16;
                4:       cap = 5'd2;
                default: cap = CFG_W'($urandom_range(0, 31));
            endcase
            write_capacity(cap);
            send_idle = (ph % 4 != 1);
            recv_idle = (ph % 4 != 2);
            if (ph == 3) begin
                // sender runs flat out against the long hold-off
                send_idle    = 1'b0;
                hold_request = 1'b1;
            end
            pool_n = $urandom_range(1, POOL_MAX);
            for (int k = 0; k < pool_n; k++)
                pool[k] = PAGE_W'($urandom);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(0, 99) < 85)
                    pg = pool[$urandom_range(0, pool_n - 1)];
                else
                    pg = PAGE_W'($urandom);
                send_page(pg, draw_gap());
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[lru_page_replacement_core.f]
hdl/lpr_pkg.sv
hdl/lpr_cell.sv
hdl/lru_page_replacement_core.sv
hdl/lpr_checker.sv
sim/tb_lru_page_replacement_core.sv
